### src/dtd_pkg.sv
package dtd_pkg;

  localparam int CountW = 16;

  // Sequencer stages of one character.
  localparam logic [1:0] STG_IDLE = 2'd0;
  localparam logic [1:0] STG_TONE = 2'd1;
  localparam logic [1:0] STG_POST = 2'd2;
  localparam logic [1:0] STG_GAP  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TONE_LEN  = 2'd0;
  localparam logic [1:0] REG_POST_GAP  = 2'd1;
  localparam logic [1:0] REG_DIGIT_GAP = 2'd2;
  localparam logic [1:0] REG_SIGNED    = 2'd3;

  localparam logic [CountW-1:0] TONE_LEN_RST  = CountW'(2800);
  localparam logic [CountW-1:0] POST_GAP_RST  = CountW'(1200);
  localparam logic [CountW-1:0] DIGIT_GAP_RST = CountW'(800);

  localparam int SampleRate = 8000;

  // Phase increments per sample, (freq * 65536) / 8000.
  localparam logic [15:0] STEP_697  = 16'((697 * 65536) / SampleRate);
  localparam logic [15:0] STEP_770  = 16'((770 * 65536) / SampleRate);
  localparam logic [15:0] STEP_852  = 16'((852 * 65536) / SampleRate);
  localparam logic [15:0] STEP_941  = 16'((941 * 65536) / SampleRate);
  localparam logic [15:0] STEP_1209 = 16'((1209 * 65536) / SampleRate);
  localparam logic [15:0] STEP_1336 = 16'((1336 * 65536) / SampleRate);
  localparam logic [15:0] STEP_1477 = 16'((1477 * 65536) / SampleRate);

  // Sine polynomial coefficients in Q16.
  localparam logic signed [19:0] COEF_0 = 20'sd205824;
  localparam logic signed [19:0] COEF_1 = 20'sd1328;
  localparam logic signed [19:0] COEF_2 = -20'sd348991;
  localparam logic signed [19:0] COEF_3 = 20'sd35696;
  localparam logic signed [19:0] COEF_4 = 20'sd117984;

  typedef struct packed {
    logic [1:0]        stage;
    logic [CountW-1:0] cnt;
  } seq_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } key_t;

  function automatic logic signed [19:0] poly_coef(input logic [2:0] i);
    logic signed [19:0] c;
    case (i)
      3'd0:    c = COEF_0;
      3'd1:    c = COEF_1;
      3'd2:    c = COEF_2;
      3'd3:    c = COEF_3;
      3'd4:    c = COEF_4;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] row_step(input logic [3:0] k);
    logic [15:0] s;
    case (k)
      4'd1, 4'd2, 4'd3:    s = STEP_697;
      4'd4, 4'd5, 4'd6:    s = STEP_770;
      4'd7, 4'd8, 4'd9:    s = STEP_852;
      4'd0, 4'd10, 4'd11:  s = STEP_941;
      default:             s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] col_step(input logic [3:0] k);
    logic [15:0] s;
    case (k)
      4'd1, 4'd4, 4'd7, 4'd10: s = STEP_1209;
      4'd0, 4'd2, 4'd5, 4'd8:  s = STEP_1336;
      4'd3, 4'd6, 4'd9, 4'd11: s = STEP_1477;
      default:                 s = '0;
    endcase
    return s;
  endfunction

  function automatic key_t key_decode(input logic [7:0] c);
    key_t k;
    k.hit = 1'b0;
    k.idx = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      k.hit = 1'b1;
      k.idx = 4'(c - 8'h30);
    end else if (c == 8'h2A) begin
      k.hit = 1'b1;
      k.idx = 4'd10;
    end else if (c == 8'h23) begin
      k.hit = 1'b1;
      k.idx = 4'd11;
    end
    return k;
  endfunction

  // Skips every stage whose count is zero; the stages always run in order.
  function automatic seq_t seq_advance(input seq_t s, input logic [CountW-1:0] post,
                                       input logic [CountW-1:0] gap);
    seq_t r;
    r = s;
    if (r.stage == STG_TONE && r.cnt == '0) begin
      r.stage = STG_POST;
      r.cnt   = post;
    end
    if (r.stage == STG_POST && r.cnt == '0) begin
      r.stage = STG_GAP;
      r.cnt   = gap;
    end
    if (r.stage == STG_GAP && r.cnt == '0) begin
      r.stage = STG_IDLE;
    end
    return r;
  endfunction

endpackage

### src/dtmf_tone_dialer.sv
// DTMF dialer producing one 8-bit audio sample for every 8 kHz tick.
// Input channel: one beat per tick carries char_valid and char_code. A key
// ('0'-'9', '*', '#') offered while the dialer is idle starts its dual tone
// for tone_len samples, then post_tone_gap and digit_gap samples of silence;
// any other character gives digit_gap samples of silence. Characters offered
// while a sequence is playing are dropped, but the tick still yields a sample.
// Output channel: exactly one beat per input beat, holding sample_byte,
// busy_res and tone_on. A silent sample is registered and ready in the cycle
// after its tick is taken. A tone sample is ready once both sines have run in
// turn through one shared 20x17 multiplier, each in a fold state and then a
// run of multiply and accumulate steps, and a mix state has combined them.
// With no output stall a silent tick can be taken every cycle.
// The input is stalled while a sample is in the works or while an earlier
// sample waits on a stalled output, so one tick is handled at a time.
// Configuration: cfg_ready is always high; registers should be written only
// while no tick is in the works. signed_samples is sampled when each byte is
// formed.
// Reset clears the sequencer to idle, zeroes both phase accumulators, drops
// any pending output beat and loads the register defaults.
module dtmf_tone_dialer
  import dtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              char_valid,
  input  logic [7:0]        char_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        sample_byte,
  output logic              busy_res,
  output logic              tone_on,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FOLD = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_MIX  = 2'd3;

  localparam logic [3:0] STEP_LAST = 4'd10;

  logic [CountW-1:0] tone_len, post_tone_gap, digit_gap;
  logic              signed_samples;

  logic [1:0]        seq_stage;
  logic [CountW-1:0] samples_left;
  logic [3:0]        key_index;
  logic [15:0]       row_phase, col_phase;

  logic [1:0]        st;
  logic              pass;
  logic [3:0]        step;
  logic [15:0]       row_work, col_work;
  logic [15:0]       mag;
  logic              neg;
  logic [15:0]       pw;
  logic signed [36:0] prod;
  logic signed [38:0] acc;
  logic signed [15:0] sin_row, sin_col;

  logic in_acc, out_acc;
  logic start;
  key_t key;
  seq_t s_cur, s_start, s_next;
  logic play, is_tone;
  logic [3:0]  key_use;
  logic [15:0] row_use, col_use;
  logic [7:0]  silence;

  assign cfg_ready = 1'b1;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (st != ST_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign silence   = signed_samples ? 8'd0 : 8'd127;

  // Sequencer step for the tick being accepted.
  always_comb begin
    s_cur.stage = seq_stage;
    s_cur.cnt   = samples_left;
    key         = key_decode(char_code);
    start       = (seq_stage == STG_IDLE) && char_valid;
    s_start     = s_cur;
    if (start) begin
      s_start.stage = key.hit ? STG_TONE : STG_GAP;
      s_start.cnt   = key.hit ? tone_len : digit_gap;
      s_start       = seq_advance(s_start, post_tone_gap, digit_gap);
    end
    play       = s_start.stage != STG_IDLE;
    is_tone    = s_start.stage == STG_TONE;
    s_next     = s_start;
    s_next.cnt = s_start.cnt - CountW'(1);
    s_next     = seq_advance(s_next, post_tone_gap, digit_gap);
    if (!play) begin
      s_next = s_start;
    end
    key_use = (start && key.hit) ? key.idx : key_index;
    row_use = (start && key.hit) ? 16'd0 : row_phase;
    col_use = (start && key.hit) ? 16'd0 : col_phase;
  end

  // Quadrant fold of the phase for the current pass.
  logic [15:0] fold_ph, fold_m;
  always_comb begin
    fold_ph = pass ? col_work : row_work;
    fold_m  = fold_ph[15] ? 16'(17'h10000 - {1'b0, fold_ph}) : fold_ph;
    if (fold_ph == 16'h8000) begin
      fold_m = '0;
    end
    if (fold_m >= 16'h4000) begin
      fold_m = 16'h8000 - fold_m;
    end
  end

  // Shared multiplier operand selection.
  logic signed [19:0] mul_a;
  logic [15:0]        mul_b;
  logic [15:0]        prod_pow;
  logic signed [36:0] mul_p;
  assign prod_pow = prod[30:15];
  always_comb begin
    if (step == 4'd0) begin
      mul_a = poly_coef(3'd0);
      mul_b = mag;
    end else if (step[0]) begin
      mul_a = signed'({4'd0, pw});
      mul_b = mag;
    end else begin
      mul_a = poly_coef(step[3:1]);
      mul_b = prod_pow;
    end
    mul_p = 37'(mul_a) * 37'(signed'({1'b0, mul_b}));
  end

  // Clamp, scale and sign of the finished polynomial.
  logic signed [22:0] acc_sh;
  logic [14:0]        sin_mag;
  logic signed [15:0] sin_val;
  always_comb begin
    acc_sh = 23'(acc >>> 16);
    if (acc < 0) begin
      sin_mag = '0;
    end else if (acc_sh > 23'sd32767) begin
      sin_mag = 15'h7FFF;
    end else begin
      sin_mag = acc_sh[14:0];
    end
    sin_val = neg ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
  end

  // Mix of the two sines into one byte; the scale by 127 is shift and subtract.
  logic signed [16:0] mix_s;
  logic [16:0]        mix_abs;
  logic [23:0]        mix_sv;
  logic [17:0]        mix_u;
  logic [24:0]        mix_uv;
  logic [7:0]         mix_byte;
  always_comb begin
    mix_s   = 17'(sin_row) + 17'(sin_col);
    mix_abs = mix_s[16] ? 17'(-mix_s) : 17'(mix_s);
    mix_sv  = ({7'd0, mix_abs} << 7) - {7'd0, mix_abs};
    mix_u   = 18'(signed'({mix_s[16], mix_s}) + 18'sd65536);
    mix_uv  = ({7'd0, mix_u} << 7) - {7'd0, mix_u};
    if (signed_samples) begin
      mix_byte = mix_s[16] ? 8'(-mix_sv[23:16]) : mix_sv[23:16];
    end else begin
      mix_byte = mix_uv[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_len       <= TONE_LEN_RST;
      post_tone_gap  <= POST_GAP_RST;
      digit_gap      <= DIGIT_GAP_RST;
      signed_samples <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TONE_LEN:  tone_len       <= cfg_data;
        REG_POST_GAP:  post_tone_gap  <= cfg_data;
        REG_DIGIT_GAP: digit_gap      <= cfg_data;
        REG_SIGNED:    signed_samples <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_stage    <= STG_IDLE;
      samples_left <= '0;
      key_index    <= '0;
      row_phase    <= '0;
      col_phase    <= '0;
      st           <= ST_IDLE;
      pass         <= 1'b0;
      step         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            seq_stage    <= s_next.stage;
            samples_left <= s_next.cnt;
            if (start && key.hit) begin
              key_index <= key.idx;
            end
            if (is_tone) begin
              row_work  <= row_use;
              col_work  <= col_use;
              row_phase <= row_use + row_step(key_use);
              col_phase <= col_use + col_step(key_use);
              pass      <= 1'b0;
              st        <= ST_FOLD;
            end else begin
              if (start && key.hit) begin
                row_phase <= '0;
                col_phase <= '0;
              end
              out_valid   <= 1'b1;
              sample_byte <= silence;
              busy_res    <= play;
              tone_on     <= 1'b0;
            end
          end
        end
        ST_FOLD: begin
          mag  <= fold_m;
          neg  <= fold_ph[15];
          step <= '0;
          st   <= ST_MAC;
        end
        ST_MAC: begin
          // Even steps multiply a coefficient by the newest power, odd steps
          // accumulate that term and form the next power.
          if (step != STEP_LAST) begin
            prod <= mul_p;
            step <= step + 4'd1;
            if (step == 4'd0) begin
              pw <= mag;
            end else if (step[0]) begin
              acc <= (step == 4'd1) ? 39'(prod) : acc + 39'(prod);
            end else begin
              pw <= prod_pow;
            end
          end else if (!pass) begin
            sin_row <= sin_val;
            pass    <= 1'b1;
            st      <= ST_FOLD;
          end else begin
            sin_col <= sin_val;
            st      <= ST_MIX;
          end
        end
        ST_MIX: begin
          out_valid   <= 1'b1;
          sample_byte <= mix_byte;
          busy_res    <= 1'b1;
          tone_on     <= 1'b1;
          st          <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule
